>>> hdl/htw_pkg.sv
// Package for the hierarchical timer wheel: opcode, result kind and status codes, pool size.
// No dependencies.
`default_nettype none
package htw_pkg;
    localparam int POOL_SIZE = 32;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] RK_ADD_ACK    = 2'd0;
    localparam logic [1:0] RK_CANCEL_ACK = 2'd1;
    localparam logic [1:0] RK_EXPIRED    = 2'd2;
    localparam logic [1:0] RK_TICK_DONE  = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FAR  = 2'd1;
    localparam logic [1:0] ST_BUSY = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] status;
        logic [4:0] id;
        logic       last;
    } result_t;
endpackage
`default_nettype wire

>>> hdl/hierarchical_timer_wheel.sv
// Top level of the hierarchical timer wheel: slot head memory, link memory, sequencer.
// Depends on htw_pkg.
//
// Channel | Direction | Ports
// s_      | in        | s_valid s_ready s_opcode s_timer_id s_expiry_time
// m_      | out       | m_valid m_ready m_result_kind m_status m_expired_id m_last
//
// A cancel passes through the S_OUT state of the sequencer and an add through S_OUT, S_PRD,
// S_NEXT and S_PWR. A tick visits S_LVL for each level, S_HRD and S_HGET for each slot it
// empties, S_WALK, S_LRD and S_LGET per timer walked and S_PRD, S_NEXT and S_PWR per timer
// relinked through the single-port slot head memory; fired timers then leave one beat each.
// After reset the slot head memory is cleared one entry a cycle, LEVELS * 2^SLOT_BITS in all.
// A stall on m_ready holds the result scan, and no item is taken while a beat waits.
`default_nettype none
module hierarchical_timer_wheel import htw_pkg::*; #(
    parameter int SLOT_BITS = 8,
    parameter int LEVELS    = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_opcode,
    input  wire logic [4:0]  s_timer_id,
    input  wire logic [63:0] s_expiry_time,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_result_kind,
    output logic [1:0]       m_status,
    output logic [4:0]       m_expired_id,
    output logic             m_last
);
    localparam int SPL  = 1 << SLOT_BITS;
    localparam int NSL  = LEVELS * SPL;
    localparam int SW   = $clog2(NSL) < 1 ? 1 : $clog2(NSL);
    localparam int LW   = $clog2(LEVELS) < 1 ? 1 : $clog2(LEVELS);
    localparam int PW   = $clog2(POOL_SIZE + 1);
    localparam int IW   = $clog2(POOL_SIZE);
    localparam int SPAN = LEVELS * SLOT_BITS;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_LVL   = 4'd2;
    localparam logic [3:0] S_HRD   = 4'd3;
    localparam logic [3:0] S_HGET  = 4'd4;
    localparam logic [3:0] S_WALK  = 4'd5;
    localparam logic [3:0] S_PRD   = 4'd6;
    localparam logic [3:0] S_PWR   = 4'd7;
    localparam logic [3:0] S_SCAN  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_NEXT  = 4'd10;
    localparam logic [3:0] S_LRD   = 4'd11;
    localparam logic [3:0] S_LGET  = 4'd12;

    // Slot head memory, single port, registered read.
    logic [PW-1:0] head_mem [NSL];
    logic [SW-1:0] h_addr;
    logic          h_we;
    logic [PW-1:0] h_wdata, h_rdata;
    always_ff @(posedge aclk) begin
        if (h_we) head_mem[h_addr] <= h_wdata;
        h_rdata <= head_mem[h_addr];
    end

    // Link memory, registered read.
    logic [PW-1:0] link_mem [POOL_SIZE];
    logic [IW-1:0] l_waddr, l_raddr;
    logic          l_we;
    logic [PW-1:0] l_wdata, l_rdata;
    always_ff @(posedge aclk) begin
        if (l_we) link_mem[l_waddr] <= l_wdata;
        l_rdata <= link_mem[l_raddr];
    end

    logic [63:0] exp_reg [POOL_SIZE];
    logic [POOL_SIZE-1:0] act_reg, lnk_reg, fired_reg;
    logic [63:0] now_reg;
    logic [3:0]  st_reg;
    logic [SW-1:0] clr_reg;
    logic [LW-1:0] lvl_reg;
    logic [SW-1:0] slot_reg;
    logic [PW-1:0] p_reg, nxt_reg;
    logic [PW-1:0] steps_reg;
    logic          relink_reg;
    logic [IW-1:0] pid_reg, scan_reg;
    logic [SW-1:0] pslot_reg;
    result_t       res_reg;
    logic          mv_reg;
    logic [1:0]    op_reg;
    logic [4:0]    id_reg;
    logic [63:0]   e_reg;

    assign m_valid       = mv_reg;
    assign m_result_kind = res_reg.kind;
    assign m_status      = res_reg.status;
    assign m_expired_id  = res_reg.id;
    assign m_last        = res_reg.last;
    assign s_ready       = (st_reg == S_IDLE) && !mv_reg;

    logic in_pool;
    assign in_pool = ({1'b0, id_reg} < 6'(POOL_SIZE));

    logic [IW-1:0] id_ix, p_ix;
    assign id_ix = id_reg[IW-1:0];
    assign p_ix  = IW'(p_reg - PW'(1));

    // Placement of pid_reg relative to now_reg.
    logic [63:0]   pd;
    logic [LW-1:0] plvl;
    logic [SW-1:0] pslot;
    always_comb begin
        pd   = exp_reg[pid_reg] - now_reg;
        plvl = '0;
        for (int l = 1; l < LEVELS; l++)
            if ((pd >> (l * SLOT_BITS)) != 64'd0) plvl = LW'(l);
        pslot = SW'((64'(plvl) << SLOT_BITS) |
                    ((exp_reg[pid_reg] >> (64'(plvl) * SLOT_BITS)) & 64'(SPL - 1)));
    end

    logic [63:0] add_d;
    assign add_d = (e_reg > now_reg) ? e_reg - now_reg : 64'd0;
    logic far;
    assign far = (SPAN >= 64) ? 1'b0 : ((add_d >> SPAN) != 64'd0);

    logic [63:0] lowmask;
    assign lowmask = (64'd1 << (64'(lvl_reg) * SLOT_BITS)) - 64'd1;

    always_comb begin
        h_addr  = slot_reg;
        h_we    = 1'b0;
        h_wdata = '0;
        l_we    = 1'b0;
        l_waddr = pid_reg;
        l_wdata = h_rdata;
        l_raddr = p_ix;
        case (st_reg)
            S_CLR: begin
                h_addr = clr_reg;
                h_we   = 1'b1;
            end
            S_HGET: begin
                h_we = 1'b1;
            end
            S_PRD: h_addr = pslot;
            S_NEXT: h_addr = pslot_reg;
            S_PWR: begin
                h_addr  = pslot_reg;
                h_we    = 1'b1;
                h_wdata = PW'({1'b0, pid_reg} + 1);
                l_we    = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= S_CLR;
            clr_reg   <= '0;
            mv_reg    <= 1'b0;
            now_reg   <= '0;
            act_reg   <= '0;
            lnk_reg   <= '0;
            fired_reg <= '0;
        end else begin
            if (mv_reg && m_ready && st_reg != S_SCAN) mv_reg <= 1'b0;
            case (st_reg)
                S_CLR: begin
                    clr_reg <= clr_reg + SW'(1);
                    if (clr_reg == SW'(NSL - 1)) st_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_valid && !mv_reg) begin
                        op_reg <= s_opcode;
                        id_reg <= s_timer_id;
                        e_reg  <= s_expiry_time;
                        if (s_opcode == OP_ADD) begin
                            st_reg <= S_OUT;
                        end else if (s_opcode == OP_CANCEL) begin
                            st_reg <= S_OUT;
                        end else if (s_opcode == OP_TICK) begin
                            now_reg <= now_reg + 64'd1;
                            lvl_reg <= LW'(LEVELS - 1);
                            st_reg  <= S_LVL;
                        end
                    end
                end
                S_OUT: begin
                    mv_reg <= 1'b1;
                    res_reg.id   <= id_reg;
                    res_reg.last <= 1'b1;
                    if (op_reg == OP_ADD) begin
                        res_reg.kind <= RK_ADD_ACK;
                        if (far) begin
                            res_reg.status <= ST_FAR;
                            st_reg <= S_IDLE;
                        end else if (!in_pool || lnk_reg[id_ix]) begin
                            res_reg.status <= ST_BUSY;
                            st_reg <= S_IDLE;
                        end else begin
                            res_reg.status <= ST_OK;
                            exp_reg[id_ix] <= (add_d == 64'd0) ? now_reg + 64'd1 : e_reg;
                            act_reg[id_ix] <= 1'b1;
                            pid_reg <= id_ix;
                            relink_reg <= 1'b0;
                            st_reg <= S_PRD;
                        end
                    end else begin
                        res_reg.kind   <= RK_CANCEL_ACK;
                        res_reg.status <= ST_OK;
                        if (in_pool) act_reg[id_ix] <= 1'b0;
                        st_reg <= S_IDLE;
                    end
                end
                S_LVL: begin
                    if (lvl_reg == '0) begin
                        slot_reg   <= SW'(now_reg[SLOT_BITS-1:0]);
                        relink_reg <= 1'b0;
                        st_reg     <= S_HRD;
                    end else if ((now_reg & lowmask) == 64'd0) begin
                        slot_reg <= SW'((64'(lvl_reg) << SLOT_BITS) |
                            ((now_reg >> (64'(lvl_reg) * SLOT_BITS)) & 64'(SPL - 1)));
                        relink_reg <= 1'b1;
                        st_reg     <= S_HRD;
                    end else begin
                        lvl_reg <= lvl_reg - LW'(1);
                    end
                end
                S_HRD: st_reg <= S_HGET;
                S_HGET: begin
                    p_reg     <= h_rdata;
                    steps_reg <= '0;
                    st_reg    <= S_WALK;
                end
                S_WALK: begin
                    if (p_reg == '0 || steps_reg == PW'(POOL_SIZE) ||
                        p_reg > PW'(POOL_SIZE)) begin
                        if (relink_reg) begin
                            lvl_reg <= lvl_reg - LW'(1);
                            st_reg  <= S_LVL;
                        end else begin
                            scan_reg <= '0;
                            st_reg   <= S_SCAN;
                        end
                    end else begin
                        st_reg <= S_LRD;
                    end
                end
                S_LRD: st_reg <= S_LGET;
                S_LGET: begin
                    nxt_reg <= l_rdata;
                    lnk_reg[p_ix] <= 1'b0;
                    steps_reg <= steps_reg + PW'(1);
                    if (act_reg[p_ix] && relink_reg) begin
                        pid_reg <= p_ix;
                        st_reg  <= S_PRD;
                    end else begin
                        if (act_reg[p_ix]) begin
                            act_reg[p_ix]   <= 1'b0;
                            fired_reg[p_ix] <= 1'b1;
                        end
                        p_reg  <= l_rdata;
                        st_reg <= S_WALK;
                    end
                end
                S_PRD: begin
                    pslot_reg <= pslot;
                    st_reg    <= S_NEXT;
                end
                S_NEXT: st_reg <= S_PWR;
                S_PWR: begin
                    lnk_reg[pid_reg] <= 1'b1;
                    if (op_reg == OP_ADD) st_reg <= S_IDLE;
                    else begin
                        p_reg  <= nxt_reg;
                        st_reg <= S_WALK;
                    end
                end
                S_SCAN: begin
                    if (!mv_reg || m_ready) begin
                        if (fired_reg[scan_reg]) begin
                            mv_reg <= 1'b1;
                            fired_reg[scan_reg] <= 1'b0;
                            res_reg.kind   <= RK_EXPIRED;
                            res_reg.status <= ST_OK;
                            res_reg.id     <= 5'(scan_reg);
                            res_reg.last   <= 1'b0;
                        end else if (fired_reg == '0) begin
                            mv_reg <= 1'b1;
                            res_reg.kind   <= RK_TICK_DONE;
                            res_reg.status <= ST_OK;
                            res_reg.id     <= '0;
                            res_reg.last   <= 1'b1;
                            st_reg <= S_IDLE;
                        end else begin
                            mv_reg   <= 1'b0;
                            scan_reg <= scan_reg + IW'(1);
                        end
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> hdl/htw_checker.sv
// Port-level checker for the hierarchical timer wheel, bound to the top level.
// Depends on htw_pkg.
`default_nettype none
module htw_checker import htw_pkg::*; (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [1:0] m_result_kind,
    input wire logic [1:0] m_status,
    input wire logic [4:0] m_expired_id,
    input wire logic       m_last
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_kind) && $stable(m_last))
        else $error("result beat dropped while stalled");
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == RK_TICK_DONE |-> m_last && m_expired_id == 5'd0)
        else $error("tick done must close the item");
    a_exp_notlast: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == RK_EXPIRED |-> !m_last && m_status == ST_OK)
        else $error("expiry beat flagged last");
    a_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("input taken mid item");
endmodule

bind hierarchical_timer_wheel htw_checker u_htw_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_result_kind(m_result_kind),
    .m_status(m_status), .m_expired_id(m_expired_id), .m_last(m_last)
);
`default_nettype wire
